[rtl/core/mplm_pkg.sv]
`default_nettype none
package mplm_pkg;

  localparam int unsigned NUM_PATTERNS = 8;
  localparam int unsigned PATTERN_LEN  = 32;
  localparam int unsigned MAX_LINE     = 255;

  localparam int unsigned PosW  = $clog2(PATTERN_LEN);
  localparam int unsigned PLenW = $clog2(PATTERN_LEN + 1);
  localparam int unsigned LineW = 8;

  localparam logic [7:0] CTRL_LIMIT = 8'h1f;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;

  typedef enum logic [1:0] {
    OP_TEXT = 2'd0,
    OP_LOAD = 2'd1,
    OP_EOS  = 2'd2,
    OP_RSVD = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_CASE_FOLD  = 2'd0,
    CFG_EXACT_LINE = 2'd1,
    CFG_INVERT     = 2'd2,
    CFG_ACTIVE     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TERM_NONE = 2'd0,
    TERM_CR   = 2'd1,
    TERM_LF   = 2'd2
  } term_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic [2:0] pattern_slot;
    logic [4:0] pattern_pos;
    logic [5:0] pattern_length;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic        line_selected;
    logic [31:0] line_number;
    logic [31:0] line_offset;
    logic [7:0]  line_length;
    logic [31:0] selected_count;
    logic        last_of_run;
  } out_word_t;

  // Broadcast from the line controller to every compare cell.
  typedef struct packed {
    logic             text_upd;
    logic             clear;
    logic [7:0]       cmp_byte;
    logic             case_fold;
    logic             exact;
    logic [7:0]       load_byte;
    logic [PosW-1:0]  load_pos;
    logic [PLenW-1:0] load_len;
    logic [LineW-1:0] cur_len;
  } cell_ctl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic cf);
    logic [7:0] r;
    r = b;
    if (cf && b >= 8'h61 && b <= 8'h7a) begin
      r = b - 8'd32;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hffff_ffff) ? v : v + 32'd1;
  endfunction

endpackage
`default_nettype wire

[rtl/core/mplm_cell.sv]
`default_nettype none
module mplm_cell
  import mplm_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cell_ctl_t  ctl_i,
  input  wire        load_sel_i,
  input  wire        active_i,
  input  wire        match_i,
  output logic       match_o
);

  logic [7:0]             pat_q [PATTERN_LEN];
  logic [PLenW-1:0]       len_q;
  logic [PATTERN_LEN-1:0] part_q, part_d, part_post;
  logic                   found_q, found_post;
  logic                   alive_q, alive_post;
  logic [LineW-1:0]       post_len;
  logic [PosW-1:0]        last_idx;
  logic                   local_hit;

  assign last_idx = PosW'(len_q - PLenW'(1));
  assign post_len = ctl_i.cur_len + LineW'(ctl_i.text_upd);

  always_comb begin
    for (int k = 0; k < PATTERN_LEN; k++) begin
      if (PLenW'(k) < len_q) begin
        part_d[k] = (fold_byte(pat_q[k], ctl_i.case_fold) == ctl_i.cmp_byte) &&
                    ((k == 0) || part_q[(k == 0) ? 0 : k - 1]);
      end else begin
        part_d[k] = part_q[k];
      end
    end
  end

  always_comb begin
    part_post  = ctl_i.text_upd ? part_d : part_q;
    found_post = found_q || (ctl_i.text_upd && (len_q != '0) && part_d[last_idx]);
    alive_post = alive_q;
    if (ctl_i.text_upd) begin
      alive_post = alive_q && (ctl_i.cur_len < LineW'(len_q)) &&
                   (fold_byte(pat_q[ctl_i.cur_len[PosW-1:0]], ctl_i.case_fold) ==
                    ctl_i.cmp_byte);
    end
    if (ctl_i.exact) begin
      local_hit = alive_post && (post_len == LineW'(len_q));
    end else begin
      local_hit = (len_q == '0) || found_post;
    end
  end

  // The match verdict ripples along the row of cells.
  assign match_o = match_i || (active_i && local_hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      part_q  <= '0;
      found_q <= 1'b0;
      alive_q <= 1'b1;
    end else begin
      if (ctl_i.clear) begin
        part_q  <= '0;
        found_q <= 1'b0;
        alive_q <= 1'b1;
      end else begin
        part_q  <= part_post;
        found_q <= found_post;
        alive_q <= alive_post;
      end
      if (load_sel_i) begin
        len_q <= (ctl_i.load_len > PLenW'(PATTERN_LEN)) ? PLenW'(PATTERN_LEN)
                                                        : ctl_i.load_len;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_sel_i) begin
      pat_q[ctl_i.load_pos] <= ctl_i.load_byte;
    end
  end

endmodule
`default_nettype wire

[rtl/core/multi_pattern_line_matcher_top.sv]
// Fixed-string line matcher. Text bytes arrive as words on the input channel
// (valid/ready); each word carries an operation: a text byte, a pattern byte
// load, or end of stream. Lines end on any control byte other than TAB, with
// CR-LF and LF-CR counted as one terminator, and are cut at 255 bytes.
// Each finished line yields a verdict word on the output channel; end of
// stream yields a summary word, preceded by a verdict if a line is open.
// A row of compare cells, one per pattern slot, updates in parallel on every
// byte and the verdict ripples along the row in the same cycle.
// Each result word is written into a registered queue when its causing word
// is accepted. Throughput: one input word per cycle while the input is
// ready; results leave the four-word queue at one per cycle while the
// receiver is ready. The input is ready while the queue has room for two
// words, so a stalled receiver halts input before overflow; nothing is lost.
// Reset clears stream state, pattern lengths and flags and enables slot 0;
// pattern bytes stay undefined until loaded. The configuration port must be
// written only while the block is idle, which the block does not enforce.
`default_nettype none
module multi_pattern_line_matcher_top
  import mplm_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  in_word_t   in_data_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output out_word_t  out_data_o,
  input  wire        cfg_we_i,
  input  wire [1:0]  cfg_idx_i,
  input  wire [3:0]  cfg_data_i
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  logic       case_fold_q, exact_q, invert_q;
  logic [3:0] active_q;

  logic [LineW-1:0] cur_len_q, cur_len_d;
  logic [31:0]      lines_q, lines_d, start_q, start_d, bytes_q, bytes_d;
  logic [31:0]      selcnt_q, selcnt_d;
  term_e            pend_q, pend_d;

  logic       acc, is_text, is_load, is_eos, is_term, swallow, upd, finish, eos_line;
  logic [7:0] b;
  logic [31:0] bytes_new, lines_new, selcnt_new;
  logic [LineW-1:0] post_len;
  logic       matched, sel;
  cell_ctl_t  ctl;
  logic [NUM_PATTERNS:0] chain;
  out_word_t  verdict, summary, push0, push1;
  logic [1:0] npush;

  out_word_t        q_mem [QDepth];
  logic [QPtrW-1:0] rd_q, wr_q;
  logic [QPtrW:0]   cnt_q;
  logic             pop;

  assign acc     = in_valid_i && in_ready_o;
  assign b       = in_data_i.data_byte;
  always_comb begin
    is_text = 1'b0;
    is_load = 1'b0;
    is_eos  = 1'b0;
    unique case (op_e'(in_data_i.operation))
      OP_TEXT: is_text = acc;
      OP_LOAD: is_load = acc;
      OP_EOS:  is_eos  = acc;
      default: ;
    endcase
  end

  assign is_term  = (b <= CTRL_LIMIT) && (b != CHAR_TAB);
  assign swallow  = is_term && (((pend_q == TERM_CR) && (b == CHAR_LF)) ||
                                ((pend_q == TERM_LF) && (b == CHAR_CR)));
  assign upd      = is_text && !is_term;
  assign post_len = cur_len_q + LineW'(upd);
  assign finish   = is_text && ((is_term && !swallow) ||
                                (!is_term && (post_len >= LineW'(MAX_LINE))));
  assign eos_line = is_eos && (cur_len_q != '0);

  assign ctl.text_upd  = upd;
  assign ctl.clear     = finish || is_eos;
  assign ctl.cmp_byte  = fold_byte(b, case_fold_q);
  assign ctl.case_fold = case_fold_q;
  assign ctl.exact     = exact_q;
  assign ctl.load_byte = b;
  assign ctl.load_pos  = in_data_i.pattern_pos;
  assign ctl.load_len  = in_data_i.pattern_length;
  assign ctl.cur_len   = cur_len_q;

  assign chain[0] = 1'b0;
  for (genvar i = 0; i < NUM_PATTERNS; i++) begin : g_cell
    mplm_cell u_cell (
      .clk_i,
      .rst_ni,
      .ctl_i      (ctl),
      .load_sel_i (is_load && (in_data_i.pattern_slot == 3'(i))),
      .active_i   (4'(i) < active_q),
      .match_i    (chain[i]),
      .match_o    (chain[i+1])
    );
  end
  assign matched = chain[NUM_PATTERNS];
  assign sel     = matched ^ invert_q;

  assign bytes_new  = sat_inc(bytes_q);
  assign lines_new  = sat_inc(lines_q);
  assign selcnt_new = sel ? sat_inc(selcnt_q) : selcnt_q;

  always_comb begin
    verdict.result_kind    = 1'b0;
    verdict.line_selected  = sel;
    verdict.line_number    = lines_new;
    verdict.line_offset    = start_q;
    verdict.line_length    = post_len;
    verdict.selected_count = selcnt_new;
    verdict.last_of_run    = !is_eos;
    summary.result_kind    = 1'b1;
    summary.line_selected  = 1'b0;
    summary.line_number    = eos_line ? lines_new : lines_q;
    summary.line_offset    = bytes_q;
    summary.line_length    = '0;
    summary.selected_count = eos_line ? selcnt_new : selcnt_q;
    summary.last_of_run    = 1'b1;
    push0 = (is_eos && !eos_line) ? summary : verdict;
    push1 = summary;
    npush = 2'(finish) + 2'(is_eos) + 2'(eos_line);
  end

  always_comb begin
    cur_len_d = cur_len_q;
    lines_d   = lines_q;
    start_d   = start_q;
    bytes_d   = bytes_q;
    selcnt_d  = selcnt_q;
    pend_d    = pend_q;
    if (is_eos) begin
      cur_len_d = '0;
      lines_d   = '0;
      start_d   = '0;
      bytes_d   = '0;
      selcnt_d  = '0;
      pend_d    = TERM_NONE;
    end else if (is_text) begin
      bytes_d = bytes_new;
      if (swallow) begin
        pend_d  = TERM_NONE;
        start_d = bytes_new;
      end else begin
        if (is_term) begin
          pend_d = (b == CHAR_CR) ? TERM_CR : ((b == CHAR_LF) ? TERM_LF : TERM_NONE);
        end else begin
          pend_d    = TERM_NONE;
          cur_len_d = post_len;
        end
        if (finish) begin
          lines_d   = lines_new;
          selcnt_d  = selcnt_new;
          start_d   = bytes_new;
          cur_len_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_fold_q <= 1'b0;
      exact_q     <= 1'b0;
      invert_q    <= 1'b0;
      active_q    <= 4'd1;
      cur_len_q   <= '0;
      lines_q     <= '0;
      start_q     <= '0;
      bytes_q     <= '0;
      selcnt_q    <= '0;
      pend_q      <= TERM_NONE;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_CASE_FOLD:  case_fold_q <= cfg_data_i[0];
          CFG_EXACT_LINE: exact_q     <= cfg_data_i[0];
          CFG_INVERT:     invert_q    <= cfg_data_i[0];
          CFG_ACTIVE:     active_q    <= cfg_data_i;
          default: ;
        endcase
      end
      cur_len_q <= cur_len_d;
      lines_q   <= lines_d;
      start_q   <= start_d;
      bytes_q   <= bytes_d;
      selcnt_q  <= selcnt_d;
      pend_q    <= pend_d;
    end
  end

  // Result queue: up to two words go in per cycle, one comes out.
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = q_mem[rd_q];
  assign in_ready_o  = (cnt_q <= (QPtrW+1)'(QDepth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_q + QPtrW'(pop);
      wr_q  <= wr_q + QPtrW'(npush);
      cnt_q <= cnt_q + (QPtrW+1)'(npush) - (QPtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (npush != 2'd0) begin
      q_mem[wr_q] <= push0;
    end
    if (npush == 2'd2) begin
      q_mem[wr_q + QPtrW'(1)] <= push1;
    end
  end

endmodule
`default_nettype wire

[rtl/core/mplm_checker.sv]
`default_nettype none
module mplm_checker
  import mplm_pkg::*;
(
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid_o,
  input wire       out_ready_i,
  input out_word_t out_data_o
);

  // A waiting result word holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // A summary always closes its run.
  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind |-> out_data_o.last_of_run)
    else $error("summary word not last of run");

  // A summary carries no verdict and no length.
  a_sum_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind |->
      !out_data_o.line_selected && (out_data_o.line_length == 8'd0))
    else $error("summary word with verdict fields set");

  // A verdict that is not last is followed at once by its summary.
  a_run_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_of_run |=>
      out_valid_o && out_data_o.result_kind)
    else $error("open run not followed by summary");

endmodule

bind multi_pattern_line_matcher_top mplm_checker u_mplm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
